/* src/abmc_pkg.sv */
package abmc_pkg;

  // Command codes carried in the cmd field
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ENABLE = 2'd1;
  localparam logic [1:0] CMD_SNOOZE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_ALARM_MINUTE     = 3'd0;
  localparam logic [2:0] REG_MELODY_SELECT    = 3'd1;
  localparam logic [2:0] REG_SNOOZE_MINUTES   = 3'd2;
  localparam logic [2:0] REG_MAX_BUZZ_MINUTES = 3'd3;
  localparam logic [2:0] REG_LED_SLOW_HALF_MS = 3'd4;
  localparam logic [2:0] REG_LED_FAST_HALF_MS = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic [23:0] MS_PER_MINUTE = 24'd60000;
  localparam logic [10:0] HALF_DAY      = 11'd720;
  localparam logic [10:0] FULL_DAY      = 11'd1440;

  // Melody ROM
  localparam int MELODY_ROWS = 7;
  localparam int ROW_WORDS   = 7;
  localparam int ROM_ROWS    = 7;
  localparam int ROWS_USED   = (MELODY_ROWS < ROM_ROWS) ? MELODY_ROWS : ROM_ROWS;
  localparam logic [2:0] LAST_ROW = 3'(ROWS_USED - 1);

  localparam logic [15:0] TUNE_ROM [ROM_ROWS][ROW_WORDS] = '{
    '{16'd200, 16'd2800, 16'd1, 16'd0,   16'd0,   16'd1, 16'd5 },
    '{16'd200, 16'd1300, 16'd1, 16'd0,   16'd0,   16'd1, 16'd10},
    '{16'd200, 16'd800,  16'd1, 16'd0,   16'd0,   16'd1, 16'd15},
    '{16'd200, 16'd300,  16'd1, 16'd0,   16'd0,   16'd1, 16'd30},
    '{16'd100, 16'd200,  16'd1, 16'd0,   16'd0,   16'd1, 16'd40},
    '{16'd100, 16'd100,  16'd1, 16'd0,   16'd0,   16'd1, 16'd60},
    '{16'd0,   16'd1000, 16'd1, 16'd200, 16'd800, 16'd1, 16'd1 }
  };

  function automatic logic [15:0] tune_word(input logic [2:0] row, input logic [2:0] col);
    logic [15:0] w;
    w = 16'd0;
    if ((32'(row) < ROM_ROWS) && (32'(col) < ROW_WORDS)) begin
      w = TUNE_ROM[row][col];
    end
    return w;
  endfunction

  typedef struct packed {
    logic [1:0]  cmd;
    logic        enable_value;
    logic [10:0] rtc_minute;
    logic        setting_alarm;
  } in_item_t;

  typedef struct packed {
    logic buzzer_on;
    logic led_on;
    logic alarm_enabled;
    logic alarm_sounding;
    logic snooze_active;
  } out_item_t;

  // Decoded configuration; minute limits already scaled to ms
  typedef struct packed {
    logic [10:0] alarm_minute;
    logic [10:0] alarm_half;
    logic [2:0]  melody_select;
    logic [23:0] snooze_limit;
    logic [23:0] buzz_limit;
    logic [9:0]  led_slow;
    logic [9:0]  led_fast;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  step;
    logic [15:0] sub_count;
    logic [15:0] row_count;
    logic [2:0]  row;
    logic        tone_phase;
    logic        pending_on;
    logic        buzzer;
    logic [15:0] tone_ms;
  } mel_state_t;

endpackage

/* src/abmc_cfg.sv */
module abmc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [abmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [abmc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output abmc_pkg::cfg_t                  cfg
);
  import abmc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic [10:0] half_nxt;

  always_comb begin
    if (cfg_wdata >= FULL_DAY) begin
      half_nxt = cfg_wdata - FULL_DAY;
    end else if (cfg_wdata >= HALF_DAY) begin
      half_nxt = cfg_wdata - HALF_DAY;
    end else begin
      half_nxt = cfg_wdata;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALARM_MINUTE: begin
          cfg_nxt.alarm_minute = cfg_wdata;
          cfg_nxt.alarm_half   = half_nxt;
        end
        REG_MELODY_SELECT:    cfg_nxt.melody_select = cfg_wdata[2:0];
        REG_SNOOZE_MINUTES:   cfg_nxt.snooze_limit = 24'(cfg_wdata[7:0]) * MS_PER_MINUTE;
        REG_MAX_BUZZ_MINUTES: cfg_nxt.buzz_limit = 24'(cfg_wdata[7:0]) * MS_PER_MINUTE;
        REG_LED_SLOW_HALF_MS: cfg_nxt.led_slow = cfg_wdata[9:0];
        REG_LED_FAST_HALF_MS: cfg_nxt.led_fast = cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_minute  <= 11'd0;
      cfg_r.alarm_half    <= 11'd0;
      cfg_r.melody_select <= 3'd0;
      cfg_r.snooze_limit  <= 24'd300000;
      cfg_r.buzz_limit    <= 24'd180000;
      cfg_r.led_slow      <= 10'd500;
      cfg_r.led_fast      <= 10'd125;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/abmc_melody.sv */
module abmc_melody (
  input  abmc_pkg::mel_state_t mel_in,
  input  logic [2:0]           melody_select,
  output abmc_pkg::mel_state_t mel_out
);
  import abmc_pkg::*;

  mel_state_t m;
  logic [2:0]  sel_row;
  logic [15:0] len;

  always_comb begin
    m   = mel_in;
    sel_row = melody_select - 3'd1;
    len = 16'd0;

    if (melody_select != 3'd0) begin
      m.row = (32'(sel_row) < ROWS_USED) ? sel_row : LAST_ROW;
    end
    if (32'(m.row) >= ROWS_USED) begin
      m.row = LAST_ROW;
    end
    if (m.step > 3'd6) begin
      m.step = 3'd0;
    end

    // end of an on/off pair: repeat it or move on
    if ((m.step == 3'd2) || (m.step == 3'd5)) begin
      m.sub_count = m.sub_count + 16'd1;
      if (m.sub_count >= tune_word(m.row, m.step)) begin
        m.step      = m.step + 3'd1;
        m.sub_count = 16'd0;
      end else begin
        m.step = m.step - 3'd2;
      end
    end

    // end of a row
    if (m.step == 3'd6) begin
      if (melody_select == 3'd0) begin
        m.row_count = m.row_count + 16'd1;
        if (m.row_count >= tune_word(m.row, 3'd6)) begin
          if (32'(m.row) + 1 < ROWS_USED) begin
            m.row = m.row + 3'd1;
          end
          m.row_count = 16'd0;
        end
      end
      m.step = 3'd0;
    end

    len = tune_word(m.row, m.step);

    // buzzer comes on one tick after an on phase begins
    if (m.pending_on) begin
      m.pending_on = 1'b0;
      if (len != 16'd0) begin
        m.buzzer = 1'b1;
      end
    end

    if (m.tone_ms >= len) begin
      m.tone_phase = !m.tone_phase;
      if (m.tone_phase) begin
        m.pending_on = 1'b1;
      end else begin
        m.buzzer = 1'b0;
      end
      m.tone_ms = 16'd0;
      m.step    = m.step + 3'd1;
    end

    mel_out = m;
  end

endmodule

/* src/abmc_ctrl.sv */
module abmc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  abmc_pkg::in_item_t  item,
  input  abmc_pkg::cfg_t      cfg,
  output abmc_pkg::out_item_t result
);
  import abmc_pkg::*;

  logic        armed_r, armed_nxt;
  logic        sounding_r, sounding_nxt;
  logic        snoozing_r, snoozing_nxt;
  logic        led_r, led_nxt;
  logic [9:0]  led_ms_r, led_ms_nxt;
  logic [23:0] sound_ms_r, sound_ms_nxt;
  logic [23:0] snooze_ms_r, snooze_ms_nxt;
  mel_state_t  mel_r, mel_nxt;

  mel_state_t  mel_tick;
  mel_state_t  mel_played;
  logic        alarm_match;
  logic        led_blink;
  logic [9:0]  led_limit;

  assign alarm_match = (cfg.alarm_minute == item.rtc_minute) ||
                       (cfg.alarm_half == item.rtc_minute);

  always_comb begin
    mel_tick = mel_r;
    mel_tick.tone_ms = (mel_r.tone_ms != 16'hFFFF) ? mel_r.tone_ms + 16'd1 : mel_r.tone_ms;
  end

  abmc_melody u_melody (
    .mel_in        (mel_tick),
    .melody_select (cfg.melody_select),
    .mel_out       (mel_played)
  );

  always_comb begin
    armed_nxt     = armed_r;
    sounding_nxt  = sounding_r;
    snoozing_nxt  = snoozing_r;
    led_nxt       = led_r;
    led_ms_nxt    = led_ms_r;
    sound_ms_nxt  = sound_ms_r;
    snooze_ms_nxt = snooze_ms_r;
    mel_nxt       = mel_r;
    led_blink     = 1'b0;
    led_limit     = cfg.led_slow;

    case (item.cmd)
      CMD_TICK: begin
        led_ms_nxt    = (led_ms_r != 10'h3FF) ? led_ms_r + 10'd1 : led_ms_r;
        sound_ms_nxt  = (sound_ms_r != 24'hFFFFFF) ? sound_ms_r + 24'd1 : sound_ms_r;
        snooze_ms_nxt = (snooze_ms_r != 24'hFFFFFF) ? snooze_ms_r + 24'd1 : snooze_ms_r;
        mel_nxt       = mel_tick;

        if (sounding_r) begin
          mel_nxt = mel_played;
          if (sound_ms_nxt >= cfg.buzz_limit) begin
            armed_nxt          = 1'b0;
            sounding_nxt       = 1'b0;
            snoozing_nxt       = 1'b0;
            mel_nxt.tone_phase = 1'b0;
            mel_nxt.buzzer     = 1'b0;
          end
        end else if (!snoozing_r && armed_r && alarm_match) begin
          sounding_nxt       = 1'b1;
          snoozing_nxt       = 1'b0;
          mel_nxt.pending_on = 1'b1;
          mel_nxt.tone_phase = 1'b1;
          mel_nxt.row_count  = 16'd0;
          mel_nxt.sub_count  = 16'd0;
          mel_nxt.step       = 3'd0;
          mel_nxt.row        = 3'd0;
          mel_nxt.tone_ms    = 16'd0;
          sound_ms_nxt       = 24'd0;
        end

        // snooze expiry sounds the alarm again
        if (snoozing_nxt && (snooze_ms_nxt >= cfg.snooze_limit)) begin
          sounding_nxt       = 1'b1;
          snoozing_nxt       = 1'b0;
          mel_nxt.pending_on = 1'b1;
          mel_nxt.tone_phase = 1'b1;
          mel_nxt.row_count  = 16'd0;
          mel_nxt.sub_count  = 16'd0;
          mel_nxt.step       = 3'd0;
          mel_nxt.row        = 3'd0;
          mel_nxt.tone_ms    = 16'd0;
          sound_ms_nxt       = 24'd0;
        end

        if (item.setting_alarm) begin
          led_blink = 1'b1;
          led_limit = cfg.led_slow;
        end else if (snoozing_nxt) begin
          led_blink = 1'b1;
          led_limit = cfg.led_fast;
        end else begin
          led_nxt = armed_nxt;
        end
        if (led_blink && (led_ms_nxt >= led_limit)) begin
          led_nxt    = !led_r;
          led_ms_nxt = 10'd0;
        end
      end
      CMD_ENABLE: begin
        armed_nxt = item.enable_value;
        if (!item.enable_value) begin
          sounding_nxt       = 1'b0;
          snoozing_nxt       = 1'b0;
          mel_nxt.tone_phase = 1'b0;
          mel_nxt.buzzer     = 1'b0;
        end
      end
      CMD_SNOOZE: begin
        armed_nxt          = 1'b1;
        sounding_nxt       = 1'b0;
        snoozing_nxt       = 1'b1;
        mel_nxt.tone_phase = 1'b0;
        mel_nxt.buzzer     = 1'b0;
        snooze_ms_nxt      = 24'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      sounding_r  <= 1'b0;
      snoozing_r  <= 1'b0;
      led_r       <= 1'b0;
      led_ms_r    <= 10'd0;
      sound_ms_r  <= 24'd0;
      snooze_ms_r <= 24'd0;
      mel_r       <= '0;
    end else if (step_en) begin
      armed_r     <= armed_nxt;
      sounding_r  <= sounding_nxt;
      snoozing_r  <= snoozing_nxt;
      led_r       <= led_nxt;
      led_ms_r    <= led_ms_nxt;
      sound_ms_r  <= sound_ms_nxt;
      snooze_ms_r <= snooze_ms_nxt;
      mel_r       <= mel_nxt;
    end
  end

  assign result.buzzer_on      = mel_nxt.buzzer;
  assign result.led_on         = led_nxt;
  assign result.alarm_enabled  = armed_nxt;
  assign result.alarm_sounding = sounding_nxt;
  assign result.snooze_active  = snoozing_nxt;

endmodule

/* src/alarm_buzzer_melody_controller.sv */
// Alarm clock buzzer and LED controller.
// Input channel (in_valid / in_stall / in_data): one command per transfer, a
// 1 ms tick, an enable write or a snooze request. Every command yields exactly
// one result on the output channel (out_valid / out_stall / out_data) holding
// the buzzer, LED and status levels after that command.
// Configuration (cfg_wr_en / cfg_index / cfg_wdata) must be written only while
// the block is idle (the block itself does not enforce this); minute limits
// are scaled to milliseconds as they are written. A command in the input
// register is processed when the result register can take it.
// Throughput: one command per cycle while out_stall is low; state update and
// melody ROM step are one pass of logic between input and result registers.
// When the receiver stalls, the result register holds and one more command may
// wait in the input register; in_stall rises only when both are full and
// out_stall is high.
// Reset (rst_n low, synchronous) clears all flags, counters and the melody
// position, empties both registers and restores the register defaults.
module alarm_buzzer_melody_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  abmc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output abmc_pkg::out_item_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [abmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [abmc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import abmc_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  cfg_t      cfg;
  logic      advance;
  logic      in_xfer;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  abmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  abmc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

/* tb/sv/tb_alarm_buzzer_melody_controller.sv */
`timescale 1ns / 1ps

module tb_alarm_buzzer_melody_controller;
  import abmc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] LAST_TUNE_ROW = 3'd6;
  localparam int unsigned MS_PER_MIN = 60000;
  localparam int unsigned HALF_DAY_MIN = 720;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  alarm_buzzer_melody_controller u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // handshake knobs: idle_pct and long_gaps shared by both sides, long_hold for out_stall only
  int unsigned idle_pct = 20;
  bit long_gaps = 1'b1;
  int unsigned long_hold = 0;
  int unsigned fails = 0;

  out_item_t levels_q[$];

  // register copies, reset values
  logic [10:0] alarm_min_r = 11'd0;
  logic [2:0] melody_r = 3'd0;
  logic [7:0] snooze_min_r = 8'd5;
  logic [7:0] buzz_min_r = 8'd3;
  logic [9:0] led_slow_r = 10'd500;
  logic [9:0] led_fast_r = 10'd125;

  // alarm state
  bit arm_f, snd_f, snz_f, led_f, ph_f, pend_f, buzz_f;
  logic [9:0] led_ms = '0;
  logic [15:0] tone_ms = '0;
  logic [23:0] sound_ms = '0;
  logic [23:0] snz_ms = '0;
  logic [2:0] seg_idx = '0;
  logic [2:0] tune_row = '0;
  logic [15:0] sub_cnt = '0;
  logic [15:0] rep_cnt = '0;

  function automatic int unsigned idle_len();
    if ($urandom_range(99) >= idle_pct) return 0;
    if (long_gaps && $urandom_range(9) == 0) return $urandom_range(20, 6);
    return $urandom_range(3, 1);
  endfunction

  // row layout: on, off, sub count, on, off, sub count, row count
  function automatic logic [15:0] melody_word(logic [2:0] r, logic [2:0] c);
    logic [6:0][15:0] w;
    case (r)
      3'd0: w = {16'd200, 16'd2800, 16'd1, 16'd0, 16'd0, 16'd1, 16'd5};
      3'd1: w = {16'd200, 16'd1300, 16'd1, 16'd0, 16'd0, 16'd1, 16'd10};
      3'd2: w = {16'd200, 16'd800, 16'd1, 16'd0, 16'd0, 16'd1, 16'd15};
      3'd3: w = {16'd200, 16'd300, 16'd1, 16'd0, 16'd0, 16'd1, 16'd30};
      3'd4: w = {16'd100, 16'd200, 16'd1, 16'd0, 16'd0, 16'd1, 16'd40};
      3'd5: w = {16'd100, 16'd100, 16'd1, 16'd0, 16'd0, 16'd1, 16'd60};
      default: w = {16'd0, 16'd1000, 16'd1, 16'd200, 16'd800, 16'd1, 16'd1};
    endcase
    return w[3'd6 - c];
  endfunction

  function automatic void silence();
    arm_f = 1'b0;
    snd_f = 1'b0;
    snz_f = 1'b0;
    ph_f = 1'b0;
    buzz_f = 1'b0;
  endfunction

  function automatic void start_melody();
    snd_f = 1'b1;
    snz_f = 1'b0;
    pend_f = 1'b1;
    ph_f = 1'b1;
    rep_cnt = '0;
    sub_cnt = '0;
    seg_idx = '0;
    tune_row = '0;
    tone_ms = '0;
    sound_ms = '0;
  endfunction

  function automatic void tune_advance();
    logic [15:0] len;
    if (melody_r != 3'd0) tune_row = melody_r - 3'd1;
    if (tune_row > LAST_TUNE_ROW) tune_row = LAST_TUNE_ROW;
    if (seg_idx > 3'd6) seg_idx = 3'd0;
    // sub-count slots loop back to the start of their on/off pair
    if (seg_idx == 3'd2 || seg_idx == 3'd5) begin
      sub_cnt = sub_cnt + 16'd1;
      if (sub_cnt >= melody_word(tune_row, seg_idx)) begin
        seg_idx = seg_idx + 3'd1;
        sub_cnt = '0;
      end else begin
        seg_idx = seg_idx - 3'd2;
      end
    end
    if (seg_idx == 3'd6) begin
      if (melody_r == 3'd0) begin
        rep_cnt = rep_cnt + 16'd1;
        if (rep_cnt >= melody_word(tune_row, 3'd6)) begin
          if (tune_row < LAST_TUNE_ROW) tune_row = tune_row + 3'd1;
          rep_cnt = '0;
        end
      end
      seg_idx = 3'd0;
    end
    len = melody_word(tune_row, seg_idx);
    // buzzer comes on one tick late, and not at all for an empty on phase
    if (pend_f) begin
      pend_f = 1'b0;
      if (len != 16'd0) buzz_f = 1'b1;
    end
    if (tone_ms >= len) begin
      ph_f = !ph_f;
      if (ph_f) pend_f = 1'b1;
      else buzz_f = 1'b0;
      tone_ms = '0;
      seg_idx = seg_idx + 3'd1;
    end
  endfunction

  function automatic out_item_t alarm_levels(in_item_t it);
    out_item_t r;
    int unsigned lim;
    case (it.cmd)
      CMD_TICK: begin
        if (led_ms != 10'h3FF) led_ms = led_ms + 10'd1;
        if (tone_ms != 16'hFFFF) tone_ms = tone_ms + 16'd1;
        if (sound_ms != 24'hFFFFFF) sound_ms = sound_ms + 24'd1;
        if (snz_ms != 24'hFFFFFF) snz_ms = snz_ms + 24'd1;
        if (snd_f) begin
          tune_advance();
          lim = 32'(buzz_min_r);
          if (sound_ms >= lim * MS_PER_MIN) silence();
        end else if (!snz_f && arm_f) begin
          if (alarm_min_r == it.rtc_minute || alarm_min_r % HALF_DAY_MIN == it.rtc_minute)
            start_melody();
        end
        lim = 32'(snooze_min_r);
        if (snz_f && snz_ms >= lim * MS_PER_MIN) start_melody();
        if (it.setting_alarm || snz_f) begin
          lim = it.setting_alarm ? 32'(led_slow_r) : 32'(led_fast_r);
          if (led_ms >= lim) begin
            led_f = !led_f;
            led_ms = '0;
          end
        end else begin
          led_f = arm_f;
        end
      end
      CMD_ENABLE: begin
        arm_f = it.enable_value;
        if (!it.enable_value) silence();
      end
      CMD_SNOOZE: begin
        silence();
        snz_ms = '0;
        arm_f = 1'b1;
        snz_f = 1'b1;
      end
      default: ;
    endcase
    r.buzzer_on = buzz_f;
    r.led_on = led_f;
    r.alarm_enabled = arm_f;
    r.alarm_sounding = snd_f;
    r.snooze_active = snz_f;
    return r;
  endfunction

  function automatic in_item_t cmd_item(logic [1:0] c, logic en, logic [10:0] rtc, logic set);
    in_item_t it;
    it.cmd = c;
    it.enable_value = en;
    it.rtc_minute = rtc;
    it.setting_alarm = set;
    return it;
  endfunction

  function automatic in_item_t pick_input();
    in_item_t it;
    int unsigned r;
    it.enable_value = ($urandom_range(3) != 0);
    it.setting_alarm = ($urandom_range(3) == 0);
    r = $urandom_range(99);
    if (r < 20) it.rtc_minute = alarm_min_r;
    else if (r < 30) it.rtc_minute = 11'(alarm_min_r % HALF_DAY_MIN);
    else it.rtc_minute = 11'($urandom_range(1439));
    r = $urandom_range(99);
    if (r < 78) it.cmd = CMD_TICK;
    else if (r < 88) it.cmd = CMD_ENABLE;
    else if (r < 97) it.cmd = CMD_SNOOZE;
    else it.cmd = CMD_UNUSED;
    return it;
  endfunction

  // ticks that never hit the alarm minute used in the melody run (alarm at 100)
  function automatic in_item_t quiet_tick();
    return cmd_item(CMD_TICK, 1'($urandom_range(1)), 11'(101 + $urandom_range(1338)),
                    $urandom_range(15) == 0);
  endfunction

  function automatic logic [31:0] pick_minutes();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return 0;
    if (r == 4) return 255;
    return $urandom_range(255);
  endfunction

  function automatic logic [31:0] pick_led_half();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return $urandom_range(8, 1);
    if (r == 5) return 1000;
    if (r == 6) return 0;
    return $urandom_range(1000, 1);
  endfunction

  task automatic send_cmd(in_item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    levels_q.push_back(alarm_levels(it));
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_levels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (levels_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ALARM_MINUTE: alarm_min_r = val[10:0];
      REG_MELODY_SELECT: melody_r = val[2:0];
      REG_SNOOZE_MINUTES: snooze_min_r = val[7:0];
      REG_MAX_BUZZ_MINUTES: buzz_min_r = val[7:0];
      REG_LED_SLOW_HALF_MS: led_slow_r = val[9:0];
      REG_LED_FAST_HALF_MS: led_fast_r = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] alarm, logic [31:0] melody, logic [31:0] snooze,
                            logic [31:0] buzz, logic [31:0] slow, logic [31:0] fast);
    wait_all_levels();
    write_reg(REG_ALARM_MINUTE, alarm);
    write_reg(REG_MELODY_SELECT, melody);
    write_reg(REG_SNOOZE_MINUTES, snooze);
    write_reg(REG_MAX_BUZZ_MINUTES, buzz);
    write_reg(REG_LED_SLOW_HALF_MS, slow);
    write_reg(REG_LED_FAST_HALF_MS, fast);
  endtask

  // match, snooze, enable and unknown command handling; alarm at 23:59
  task automatic test_commands();
    set_config(1439, 0, 255, 255, 1000, 1000);
    send_cmd(cmd_item(CMD_TICK, 1'b1, 11'd719, 1'b0));
    send_cmd(cmd_item(CMD_UNUSED, 1'b1, 11'd0, 1'b1));
    send_cmd(cmd_item(CMD_ENABLE, 1'b1, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd1439, 1'b1));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b1, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_UNUSED, 1'b0, 11'd1439, 1'b0));
    send_cmd(cmd_item(CMD_SNOOZE, 1'b0, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd1439, 1'b0));
    send_cmd(cmd_item(CMD_SNOOZE, 1'b1, 11'd1439, 1'b1));
    send_cmd(cmd_item(CMD_ENABLE, 1'b0, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_SNOOZE, 1'b0, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_ENABLE, 1'b1, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_ENABLE, 1'b0, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_ENABLE, 1'b1, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd719, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd1439, 1'b1));
    send_cmd(cmd_item(CMD_ENABLE, 1'b0, 11'd1439, 1'b1));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd1439, 1'b0));
  endtask

  // zero timeout, zero snooze and zero LED intervals
  task automatic test_zero_limits();
    set_config(0, 7, 0, 0, 0, 0);
    send_cmd(cmd_item(CMD_ENABLE, 1'b1, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd0, 1'b1));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd5, 1'b1));
    send_cmd(cmd_item(CMD_SNOOZE, 1'b0, 11'd5, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd5, 1'b0));
    send_cmd(cmd_item(CMD_SNOOZE, 1'b0, 11'd5, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd5, 1'b1));
    repeat (3) send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd5, 1'b1));
    send_cmd(cmd_item(CMD_ENABLE, 1'b0, 11'd0, 1'b0));
  endtask

  // fixed rows: the last row has an empty on phase, row 5 toggles every 100 ms
  task automatic test_row_select();
    set_config(600, 7, 5, 255, 500, 125);
    send_cmd(cmd_item(CMD_ENABLE, 1'b1, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd600, 1'b0));
    repeat (8) send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd601, 1'b0));
    send_cmd(cmd_item(CMD_ENABLE, 1'b0, 11'd0, 1'b0));
    set_config(600, 6, 5, 255, 500, 125);
    send_cmd(cmd_item(CMD_ENABLE, 1'b1, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd600, 1'b0));
    repeat (130) send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd601, $urandom_range(7) == 0));
    send_cmd(cmd_item(CMD_ENABLE, 1'b0, 11'd0, 1'b0));
  endtask

  // melody walk from row 0, then a zero-length snooze that sounds the alarm
  // again on the next tick
  task automatic test_long_melody();
    set_config(100, 0, 0, 1, 1, 3);
    idle_pct = 5;
    long_gaps = 1'b0;
    send_cmd(cmd_item(CMD_ENABLE, 1'b1, 11'd0, 1'b0));
    send_cmd(cmd_item(CMD_TICK, 1'b0, 11'd100, 1'b0));
    repeat (60) send_cmd(quiet_tick());
    send_cmd(cmd_item(CMD_SNOOZE, 1'b0, 11'd0, 1'b0));
    repeat (40) send_cmd(quiet_tick());
    send_cmd(cmd_item(CMD_ENABLE, 1'b0, 11'd0, 1'b0));
    wait_all_levels();
    idle_pct = 20;
    long_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_all_levels();
    long_hold = 200;
    repeat (30) send_cmd(pick_input());
    wait_all_levels();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 5; p++) begin
      set_config($urandom_range(1439), $urandom_range(7), pick_minutes(), pick_minutes(),
                 pick_led_half(), pick_led_half());
      idle_pct = (p == 0) ? 0 : $urandom_range(50, 5);
      repeat (50) send_cmd(pick_input());
    end
    idle_pct = 20;
  endtask

  task automatic compare_level(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %b, got %b", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (levels_q.size() == 0) begin
        $error("result transfer with no command outstanding: %b", out_data);
        fails++;
      end else begin
        want = levels_q.pop_front();
        compare_level("buzzer_on", want.buzzer_on, out_data.buzzer_on);
        compare_level("led_on", want.led_on, out_data.led_on);
        compare_level("alarm_enabled", want.alarm_enabled, out_data.alarm_enabled);
        compare_level("alarm_sounding", want.alarm_sounding, out_data.alarm_sounding);
        compare_level("snooze_active", want.snooze_active, out_data.snooze_active);
      end
    end
  end

  initial begin : stall_drive
    int unsigned run;
    run = 0;
    forever begin
      @(posedge clk);
      if (long_hold != 0) begin
        out_stall <= 1'b1;
        long_hold--;
      end else if (run != 0) begin
        out_stall <= 1'b1;
        run--;
      end else begin
        out_stall <= 1'b0;
        run = idle_len();
      end
    end
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_zero_limits();
    test_row_select();
    test_long_melody();
    test_backpressure();
    test_random_phases();
    wait_all_levels();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
src/abmc_pkg.sv
src/abmc_cfg.sv
src/abmc_melody.sv
src/abmc_ctrl.sv
src/alarm_buzzer_melody_controller.sv
tb/sv/tb_alarm_buzzer_melody_controller.sv
